// ===== rtl/qfd_pkg.sv =====
`default_nettype none
package qfd_pkg;

  localparam int SigW   = 113;           // significand with hidden bit
  localparam int QBits  = 114;           // quotient bits plus round bit
  localparam int RemW   = 115;           // partial remainder
  localparam int ExpW   = 18;            // signed working exponent
  localparam int CntW   = 7;

  localparam logic [14:0] EXP_MAX = 15'h7fff;
  localparam logic [14:0] BIAS    = 15'h3fff;

  localparam logic [4:0] FL_NV = 5'h10;
  localparam logic [4:0] FL_OF = 5'h08;
  localparam logic [4:0] FL_UF = 5'h04;
  localparam logic [4:0] FL_DZ = 5'h02;
  localparam logic [4:0] FL_NX = 5'h01;

  localparam logic [1:0] RM_NEAR = 2'd0;
  localparam logic [1:0] RM_ZERO = 2'd1;
  localparam logic [1:0] RM_UP   = 2'd2;
  localparam logic [1:0] RM_DOWN = 2'd3;

  localparam logic REG_ROUND = 1'b0;
  localparam logic REG_TRAP  = 1'b1;

  localparam logic [63:0] QUIET_BIT = 64'h0000_8000_0000_0000;
  localparam logic [63:0] DNAN_HI   = 64'h7fff_ffff_ffff_ffff;

  // one classified operation handed from front to back
  typedef struct packed {
    logic                   special;
    logic [63:0]            spec_hi;
    logic [63:0]            spec_lo;
    logic [4:0]             spec_fl;
    logic                   sign;
    logic [SigW-1:0]        mx;
    logic [SigW-1:0]        my;
    logic signed [ExpW-1:0] ez;
  } qfd_item_t;

endpackage
`default_nettype wire

// ===== rtl/qfd_front.sv =====
`default_nettype none
module qfd_front import qfd_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [63:0] xh_in,
  input  wire logic [63:0] xl_in,
  input  wire logic [63:0] yh_in,
  input  wire logic [63:0] yl_in,
  output logic             push,
  input  wire logic        push_ready,
  output qfd_item_t        item
);

  typedef enum logic [1:0] {IDLE, CLASS, NORM} state_t;
  state_t state;

  logic [63:0] xh, xl, yh, yl;
  logic [SigW-1:0] mx, my;
  logic signed [ExpW-1:0] ex, ey;

  logic [14:0] xe, ye;
  logic xnan, ynan, xsnan, ysnan, xzero, yzero, sign;
  logic spec;
  logic [63:0] s_hi, s_lo;
  logic [4:0] s_fl;

  assign xe    = xh[62:48];
  assign ye    = yh[62:48];
  assign xnan  = (xe == EXP_MAX) && ((xh[47:0] != '0) || (xl != '0));
  assign ynan  = (ye == EXP_MAX) && ((yh[47:0] != '0) || (yl != '0));
  assign xsnan = xnan && !xh[47];
  assign ysnan = ynan && !yh[47];
  assign xzero = (xh[62:0] == '0) && (xl == '0);
  assign yzero = (yh[62:0] == '0) && (yl == '0);
  assign sign  = xh[63] ^ yh[63];

  // classify NaN, infinity and zero operands
  always_comb begin
    spec = 1'b1;
    s_hi = '0;
    s_lo = '0;
    s_fl = '0;
    if ((xe == EXP_MAX) || (ye == EXP_MAX)) begin
      if (ynan) begin
        if (ysnan) begin
          s_hi = yh | QUIET_BIT; s_lo = yl; s_fl = FL_NV;
        end else if (xsnan) begin
          s_hi = xh | QUIET_BIT; s_lo = xl; s_fl = FL_NV;
        end else begin
          s_hi = yh; s_lo = yl;
        end
      end else if (xnan) begin
        s_hi = xh | QUIET_BIT; s_lo = xl;
        if (xsnan) s_fl = FL_NV;
      end else if (xe == EXP_MAX) begin
        if (ye == EXP_MAX) begin
          s_hi = DNAN_HI; s_lo = '1; s_fl = FL_NV;
        end else begin
          s_hi = {sign, EXP_MAX, 48'h0};
        end
      end else begin
        s_hi = {sign, 63'h0};
      end
    end else if (xzero || yzero) begin
      if (xzero && yzero) begin
        s_hi = DNAN_HI; s_lo = '1; s_fl = FL_NV;
      end else if (xzero) begin
        s_hi = {sign, 63'h0};
      end else begin
        s_hi = {sign, EXP_MAX, 48'h0}; s_fl = FL_DZ;
      end
    end else begin
      spec = 1'b0;
    end
  end

  assign in_ready = (state == IDLE);

  always_comb begin
    item.special = spec;
    item.spec_hi = s_hi;
    item.spec_lo = s_lo;
    item.spec_fl = s_fl;
    item.sign    = sign;
    item.mx      = mx;
    item.my      = my;
    item.ez      = ex - ey + ExpW'(BIAS);
    push = ((state == CLASS) && spec) ||
           ((state == NORM) && mx[SigW-1] && my[SigW-1]);
  end

  // capture, then normalize denormal significands one bit a cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= IDLE;
    end else begin
      unique case (state)
        IDLE: begin
          if (in_valid) begin
            xh <= xh_in; xl <= xl_in; yh <= yh_in; yl <= yl_in;
            state <= CLASS;
          end
        end
        CLASS: begin
          mx <= {xe != '0, xh[47:0], xl};
          my <= {ye != '0, yh[47:0], yl};
          ex <= (xe != '0) ? ExpW'(xe) : ExpW'(1);
          ey <= (ye != '0) ? ExpW'(ye) : ExpW'(1);
          if (!spec) state <= NORM;
          else if (push_ready) state <= IDLE;
        end
        NORM: begin
          if (!mx[SigW-1]) begin
            mx <= {mx[SigW-2:0], 1'b0};
            ex <= ex - ExpW'(1);
          end else if (!my[SigW-1]) begin
            my <= {my[SigW-2:0], 1'b0};
            ey <= ey - ExpW'(1);
          end else if (push_ready) begin
            state <= IDLE;
          end
        end
        default: state <= IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire

// ===== rtl/qfd_queue.sv =====
`default_nettype none
module qfd_queue import qfd_pkg::*; (
  input  wire logic  clk,
  input  wire logic  rst,
  input  wire logic  wr_valid,
  output logic       wr_ready,
  input  qfd_item_t  wr_item,
  output logic       rd_valid,
  input  wire logic  rd_ready,
  output qfd_item_t  rd_item
);

  qfd_item_t slots [2];
  logic      wp, rp;
  logic [1:0] count;
  logic      wr_go, rd_go;

  assign wr_ready = (count != 2'd2);
  assign rd_valid = (count != 2'd0);
  assign wr_go    = wr_valid && wr_ready;
  assign rd_go    = rd_valid && rd_ready;
  assign rd_item  = slots[rp];

  // two-entry ring between classify and divide
  always_ff @(posedge clk) begin
    if (wr_go) slots[wp] <= wr_item;
    if (rst) begin
      wp <= 1'b0; rp <= 1'b0; count <= '0;
    end else begin
      if (wr_go) wp <= ~wp;
      if (rd_go) rp <= ~rp;
      count <= count + {1'b0, wr_go} - {1'b0, rd_go};
    end
  end

endmodule
`default_nettype wire

// ===== rtl/qfd_back.sv =====
`default_nettype none
module qfd_back import qfd_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic [1:0]  rmode,
  input  wire logic [4:0]  tenable,
  input  wire logic        pop_valid,
  output logic             pop,
  input  qfd_item_t        item,
  output logic             o_valid,
  input  wire logic        o_ready,
  output logic [63:0]      o_hi,
  output logic [63:0]      o_lo,
  output logic [4:0]       o_exc,
  output logic             o_trap,
  output logic [4:0]       o_acc
);

  typedef enum logic [2:0] {IDLE, DIV, SHIFT, ROUND, EMIT} state_t;
  state_t state;

  logic                   sign, sticky;
  logic [RemW-1:0]        rem;
  logic [SigW-1:0]        my;
  logic [QBits-1:0]       q;
  logic signed [ExpW-1:0] ez;
  logic [CntW-1:0]        cnt;
  logic [63:0]            res_hi, res_lo;
  logic [4:0]             res_fl, acc;

  // quotient digit select
  logic            ge;
  logic [RemW-1:0] diff;
  assign ge   = rem >= RemW'(my);
  assign diff = rem - RemW'(my);

  // denormal right shift with lost-bit detection
  logic                   tiny, shbig, lost;
  logic signed [ExpW-1:0] shamt;
  logic [QBits-1:0]       mask;
  assign tiny  = (ez <= 0);
  assign shbig = (ez <= -ExpW'(113));
  assign shamt = ExpW'(1) - ez;
  assign mask  = ~({QBits{1'b1}} << shamt[CntW-1:0]);
  assign lost  = tiny && (shbig ? (q != '0) : ((q & mask) != '0));

  // rounding and packing
  logic [1:0]       rm2;
  logic             rbit, inx, up;
  logic [SigW-1:0]  m;
  logic [SigW:0]    msum;
  logic [SigW-1:0]  mf;
  logic signed [ExpW-1:0] ezf;
  logic [63:0]      r_hi, r_lo;
  logic [4:0]       r_fl;

  always_comb begin
    rm2  = sign ? (rmode ^ {1'b0, rmode[1]}) : rmode;
    rbit = q[0];
    m    = q[QBits-1:1];
    inx  = rbit || sticky;
    up   = inx && ((rm2 == RM_UP) || ((rm2 == RM_NEAR) && rbit && (sticky || m[0])));
    msum = {1'b0, m} + (SigW+1)'(up);
    r_fl = inx ? FL_NX : 5'h0;
    mf   = msum[SigW] ? msum[SigW:1] : msum[SigW-1:0];
    ezf  = msum[SigW] ? ez + ExpW'(1) : ez;
    if (tiny) begin
      r_hi = {sign, 14'h0, msum[112:64]};
      r_lo = msum[63:0];
      if (inx || tenable[2]) r_fl = r_fl | FL_UF;
    end else if (ezf >= ExpW'(EXP_MAX)) begin
      if ((rm2 == RM_NEAR) || (rm2 == RM_UP)) begin
        r_hi = {sign, EXP_MAX, 48'h0};
        r_lo = '0;
      end else begin
        r_hi = {sign, 15'h7ffe, {48{1'b1}}};
        r_lo = '1;
      end
      r_fl = FL_OF | FL_NX;
    end else begin
      r_hi = {sign, ezf[14:0], mf[111:64]};
      r_lo = mf[63:0];
    end
  end

  assign pop = (state == IDLE) && pop_valid;

  logic trap_n;
  assign trap_n = (res_fl & tenable) != '0;

  // one operation at a time: divide, denormalize, round, deliver
  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= IDLE;
      o_valid <= 1'b0;
      acc     <= '0;
    end else begin
      if (o_valid && o_ready && (state != EMIT)) o_valid <= 1'b0;
      unique case (state)
        IDLE: begin
          if (pop_valid) begin
            sign <= item.sign;
            my   <= item.my;
            q    <= '0;
            cnt  <= '0;
            res_hi <= item.spec_hi;
            res_lo <= item.spec_lo;
            res_fl <= item.spec_fl;
            if (item.mx < item.my) begin
              rem <= {1'b0, item.mx, 1'b0};
              ez  <= item.ez - ExpW'(1);
            end else begin
              rem <= {2'b0, item.mx};
              ez  <= item.ez;
            end
            state <= item.special ? EMIT : DIV;
          end
        end
        DIV: begin
          q   <= {q[QBits-2:0], ge};
          rem <= ge ? {diff[RemW-2:0], 1'b0} : {rem[RemW-2:0], 1'b0};
          cnt <= cnt + CntW'(1);
          if (cnt == CntW'(QBits - 1)) state <= SHIFT;
        end
        SHIFT: begin
          sticky <= (rem != '0) || lost;
          if (tiny) begin
            if (shbig) begin
              q <= '0;
            end else begin
              q <= q >> shamt[CntW-1:0];
            end
          end
          state <= ROUND;
        end
        ROUND: begin
          res_hi <= r_hi;
          res_lo <= r_lo;
          res_fl <= r_fl;
          state  <= EMIT;
        end
        EMIT: begin
          if (!o_valid || o_ready) begin
            o_valid <= 1'b1;
            o_hi    <= res_hi;
            o_lo    <= res_lo;
            o_exc   <= res_fl;
            o_trap  <= trap_n;
            o_acc   <= trap_n ? acc : (acc | res_fl);
            if (!trap_n) acc <= acc | res_fl;
            state   <= IDLE;
          end
        end
        default: state <= IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire

// ===== rtl/quad_float_divide.sv =====
// Binary128 divider with IEEE rounding and SPARC-style flags.
// Input stream s_*: one word holds both operands (see tdata comment).
// Output stream m_*: quotient, current flags, trap bit and accrued flags.
// Config port: wr_en/wr_index/wr_data; index 0 rounding mode, index 1
// trap enables. Write only while the block is idle.
// Finite operands take 114 radix-2 divide steps in the back end, after
// each denormal operand is normalized one bit a cycle in the front end;
// NaN, infinity and zero operands skip both normalization and divide.
// Throughput: one word per divide; the front end classifies and
// normalizes the next word while the back end divides, through a
// two-entry queue.
// Reset clears config, accrued flags and all valid state.
// If the receiver stalls, the result holds in the output register and
// the back end waits; the front end keeps taking words until the queue
// fills.
`default_nettype none
module quad_float_divide import qfd_pkg::*; (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         s_tvalid,
  output logic              s_tready,
  // dividend_hi, dividend_lo, divisor_hi, divisor_lo
  input  wire logic [255:0] s_tdata,
  output logic              m_tvalid,
  input  wire logic         m_tready,
  // quotient_hi, quotient_lo, exceptions, trap, accrued_view, zero pad
  output logic [143:0]      m_tdata,
  input  wire logic         wr_en,
  input  wire logic         wr_index,
  input  wire logic [4:0]   wr_data
);

  logic [1:0] rmode;
  logic [4:0] tenable;

  // config registers
  always_ff @(posedge clk) begin
    if (rst) begin
      rmode <= RM_NEAR; tenable <= '0;
    end else if (wr_en) begin
      unique case (wr_index)
        REG_ROUND: rmode   <= wr_data[1:0];
        REG_TRAP:  tenable <= wr_data;
        default:   rmode   <= rmode;
      endcase
    end
  end

  qfd_item_t f_item, b_item;
  logic f_push, f_ready, b_valid, b_pop;
  logic [63:0] o_hi, o_lo;
  logic [4:0] o_exc, o_acc;
  logic o_trap;

  qfd_front u_front (
    .clk, .rst,
    .in_valid(s_tvalid), .in_ready(s_tready),
    .xh_in(s_tdata[63:0]), .xl_in(s_tdata[127:64]),
    .yh_in(s_tdata[191:128]), .yl_in(s_tdata[255:192]),
    .push(f_push), .push_ready(f_ready), .item(f_item)
  );

  qfd_queue u_queue (
    .clk, .rst,
    .wr_valid(f_push), .wr_ready(f_ready), .wr_item(f_item),
    .rd_valid(b_valid), .rd_ready(b_pop), .rd_item(b_item)
  );

  qfd_back u_back (
    .clk, .rst, .rmode, .tenable,
    .pop_valid(b_valid), .pop(b_pop), .item(b_item),
    .o_valid(m_tvalid), .o_ready(m_tready),
    .o_hi, .o_lo, .o_exc, .o_trap, .o_acc
  );

  assign m_tdata = {5'h0, o_acc, o_trap, o_exc, o_lo, o_hi};

`ifndef SYNTH
  a_trap_has_flag: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && o_trap |-> (o_exc & tenable) != '0)
    else $error("trap without enabled flag");
  a_acc_covers: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !o_trap |-> (o_exc & ~o_acc) == '0)
    else $error("accrued flags miss current flags");
  a_reset_idle: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("output valid after reset");
`endif

endmodule
`default_nettype wire

// ===== verif/tb.sv =====
`default_nettype none
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import qfd_pkg::*;

  localparam int WatchLimit = 6000;

  typedef struct {
    logic [63:0] hi;
    logic [63:0] lo;
    logic [4:0]  fl;
    logic        trap;
    logic [4:0]  acc;
  } quot_t;

  // directed row: operands plus an optional typed quotient and flags
  typedef struct {
    logic [63:0] xh, xl, yh, yl;
    bit          typed;
    logic [63:0] qh, ql;
    logic [4:0]  fl;
  } row_t;

  logic         clk = 1'b0;
  logic         rst = 1'b1;
  logic         s_tvalid = 1'b0;
  logic         s_tready;
  // dividend_hi, dividend_lo, divisor_hi, divisor_lo
  logic [255:0] s_tdata = '0;
  logic         m_tvalid;
  logic         m_tready = 1'b0;
  // quotient_hi, quotient_lo, exceptions, trap, accrued_view, zero pad
  logic [143:0] m_tdata;
  logic         wr_en = 1'b0;
  logic         wr_index = 1'b0;
  logic [4:0]   wr_data = '0;

  // typed expectation that travels with the word on the bus
  logic         word_typed = 1'b0;
  logic [63:0]  word_qh = '0, word_ql = '0;
  logic [4:0]   word_fl = '0;

  logic [1:0]   round_mode = RM_NEAR;
  logic [4:0]   trap_mask = '0;
  logic [4:0]   accrued = '0;
  quot_t        quot_queue[$];
  int           errors = 0;
  int           words_in = 0, words_out = 0, traps_seen = 0, inexact_seen = 0;
  int           idle_cycles = 0;
  bit           calm = 1'b0;

  quad_float_divide u_dut (
    .clk, .rst, .s_tvalid, .s_tready, .s_tdata,
    .m_tvalid, .m_tready, .m_tdata, .wr_en, .wr_index, .wr_data
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // significand with bit 112 set, exponent adjusted for denormals
  function automatic logic [127:0] normalize(input logic [63:0] h, input logic [63:0] l,
                                             output int e);
    logic [127:0] m;
    m = {16'h0, h[47:0], l};
    e = int'(h[62:48]);
    if (e != 0) begin
      m[112] = 1'b1;
    end else begin
      e = 1;
      while (!m[112]) begin
        m = m << 1;
        e--;
      end
    end
    return m;
  endfunction

  function automatic bit is_nan(logic [63:0] h, logic [63:0] l);
    return h[62:48] == EXP_MAX && (h[47:0] != 0 || l != 0);
  endfunction

  // compute the quotient, flags and accrued update for one word
  function automatic quot_t divide_predict(logic [63:0] xh, xl, yh, yl);
    quot_t        r;
    logic         sgn;
    logic [63:0]  sbit;
    logic [4:0]   fl;
    logic [127:0] mx, my, q, m;
    int           ex, ey, ez, sh;
    bit           sticky, tiny, rbit, up;
    logic [1:0]   rm;
    sgn = xh[63] ^ yh[63];
    sbit = {sgn, 63'h0};
    fl = '0;
    r.hi = '0;
    r.lo = '0;
    if (xh[62:48] == EXP_MAX || yh[62:48] == EXP_MAX) begin
      if (is_nan(yh, yl)) begin
        if (!yh[47]) begin
          r.hi = yh | QUIET_BIT; r.lo = yl; fl = FL_NV;
        end else if (is_nan(xh, xl) && !xh[47]) begin
          r.hi = xh | QUIET_BIT; r.lo = xl; fl = FL_NV;
        end else begin
          r.hi = yh; r.lo = yl;
        end
      end else if (is_nan(xh, xl)) begin
        r.hi = xh | QUIET_BIT; r.lo = xl;
        if (!xh[47]) fl = FL_NV;
      end else if (xh[62:48] == EXP_MAX) begin
        if (yh[62:48] == EXP_MAX) begin
          r.hi = DNAN_HI; r.lo = '1; fl = FL_NV;
        end else begin
          r.hi = sbit | 64'h7fff_0000_0000_0000;
        end
      end else begin
        r.hi = sbit;
      end
    end else if (xh[62:0] == 0 && xl == 0 || yh[62:0] == 0 && yl == 0) begin
      if (xh[62:0] == 0 && xl == 0 && yh[62:0] == 0 && yl == 0) begin
        r.hi = DNAN_HI; r.lo = '1; fl = FL_NV;
      end else if (xh[62:0] == 0 && xl == 0) begin
        r.hi = sbit;
      end else begin
        r.hi = sbit | 64'h7fff_0000_0000_0000; fl = FL_DZ;
      end
    end else begin
      mx = normalize(xh, xl, ex);
      my = normalize(yh, yl, ey);
      rm = round_mode;
      // negative result: up becomes toward zero, down away from zero
      if (sgn) rm = rm ^ (rm >> 1);
      ez = ex - ey + int'(BIAS);
      if (mx < my) begin
        mx = mx << 1;
        ez--;
      end
      q = '0;
      for (int i = 0; i < 114; i++) begin
        q = q << 1;
        if (mx >= my) begin
          mx = mx - my;
          q[0] = 1'b1;
        end
        mx = mx << 1;
      end
      sticky = mx != 0;
      tiny = ez <= 0;
      if (tiny) begin
        sh = 1 - ez;
        if (sh >= 128) begin
          if (q != 0) sticky = 1'b1;
          q = '0;
        end else begin
          if ((q & ((128'd1 << sh) - 1)) != 0) sticky = 1'b1;
          q = q >> sh;
        end
      end
      rbit = q[0];
      m = q >> 1;
      up = 1'b0;
      if (rbit || sticky) begin
        fl |= FL_NX;
        if (rm == RM_UP) up = 1'b1;
        else if (rm == RM_NEAR) up = rbit && (sticky || m[0]);
      end
      if (up) m = m + 1;
      if (tiny) begin
        r.hi = sbit | m[127:64];
        r.lo = m[63:0];
        if ((fl & FL_NX) != 0 || (trap_mask & FL_UF) != 0) fl |= FL_UF;
      end else begin
        if (m[113]) begin
          m = m >> 1;
          ez++;
        end
        if (ez >= int'(EXP_MAX)) begin
          if (rm == RM_NEAR || rm == RM_UP) begin
            r.hi = sbit | 64'h7fff_0000_0000_0000; r.lo = '0;
          end else begin
            r.hi = sbit | 64'h7ffe_ffff_ffff_ffff; r.lo = '1;
          end
          fl |= FL_OF | FL_NX;
        end else begin
          r.hi = sbit | {1'b0, ez[14:0], m[111:64]};
          r.lo = m[63:0];
        end
      end
    end
    r.fl = fl;
    r.trap = (fl & trap_mask) != 0;
    if (!r.trap) accrued = accrued | fl;
    r.acc = accrued;
    return r;
  endfunction

  // random operand mixing normals, denormals and special encodings
  function automatic logic [127:0] rand_operand();
    logic [63:0]  h, l;
    logic [111:0] frac;
    int           k;
    k = $urandom_range(0, 99);
    h = {$urandom, $urandom};
    l = {$urandom, $urandom};
    frac = {h[47:0], l};
    if (k < 55) begin
      case ($urandom_range(0, 3))
        0, 1: h[62:48] = 15'(int'(BIAS) - 120 + $urandom_range(0, 240));
        2: h[62:48] = 15'($urandom_range(1, 32766));
        default: h[62:48] = $urandom_range(0, 1) ? 15'($urandom_range(1, 40))
                                                 : 15'($urandom_range(32726, 32766));
      endcase
    end else if (k < 65) begin
      frac = frac >> $urandom_range(0, 111);
      if (frac == 0) frac[0] = 1'b1;
      h = {h[63], 15'h0, frac[111:64]};
      l = frac[63:0];
    end else if (k < 72) begin
      h = {h[63], 63'h0}; l = '0;
    end else if (k < 78) begin
      h = {h[63], EXP_MAX, 48'h0}; l = '0;
    end else if (k < 84) begin
      h[62:47] = {EXP_MAX, 1'b1};
    end else if (k < 90) begin
      h[62:47] = {EXP_MAX, 1'b0};
      if (h[46:0] == 0 && l == 0) l[0] = 1'b1;
    end
    return {h, l};
  endfunction

  // offer one word and hold it until the block takes it
  task automatic send_word(logic [63:0] xh, xl, yh, yl, bit typed,
                           logic [63:0] qh, ql, logic [4:0] fl);
    if (!calm && $urandom_range(0, 99) < 29) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= {yl, yh, xl, xh};
    word_typed <= typed;
    word_qh <= qh;
    word_ql <= ql;
    word_fl <= fl;
    do @(posedge clk); while (!s_tready);
  endtask

  // drain, let the block settle, then write both registers
  task automatic set_config(logic [1:0] rm, logic [4:0] te);
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (quot_queue.size() != 0) @(posedge clk);
    repeat (12) @(posedge clk);
    wr_en <= 1'b1;
    wr_index <= REG_ROUND;
    wr_data <= {3'b0, rm};
    @(posedge clk);
    round_mode = rm;
    wr_index <= REG_TRAP;
    wr_data <= te;
    @(posedge clk);
    trap_mask = te;
    wr_en <= 1'b0;
  endtask

  // predict on each accepted input word
  always @(posedge clk) begin
    quot_t e;
    if (!rst && s_tvalid && s_tready) begin
      e = divide_predict(s_tdata[63:0], s_tdata[127:64], s_tdata[191:128],
                         s_tdata[255:192]);
      if (word_typed) begin
        e.hi = word_qh;
        e.lo = word_ql;
        e.fl = word_fl;
      end
      quot_queue.push_back(e);
      words_in++;
    end
  end

  // check each accepted result word against the oldest expectation
  always @(posedge clk) begin
    quot_t e;
    if (!rst && m_tvalid && m_tready) begin
      words_out++;
      if (quot_queue.size() == 0) begin
        $display("%0t: unexpected result word %h", $realtime, m_tdata);
        errors++;
      end else begin
        e = quot_queue.pop_front();
        if (m_tdata[63:0] != e.hi || m_tdata[127:64] != e.lo || m_tdata[132:128] != e.fl
            || m_tdata[133] != e.trap || m_tdata[138:134] != e.acc) begin
          $display("%0t: mismatch expected q=%h_%h fl=%h trap=%b acc=%h", $realtime,
                   e.hi, e.lo, e.fl, e.trap, e.acc);
          $display("%0t:          actual   q=%h_%h fl=%h trap=%b acc=%h", $realtime,
                   m_tdata[63:0], m_tdata[127:64], m_tdata[132:128], m_tdata[133],
                   m_tdata[138:134]);
          errors++;
        end
        if (e.trap) traps_seen++;
        if (e.fl[0]) inexact_seen++;
      end
    end
  end

  // stall the result side at random
  always @(posedge clk) begin
    m_tready <= calm || $urandom_range(0, 99) >= 29;
  end

  // end the run when nothing moves for too long
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WatchLimit) begin
        $display("%0t: watchdog expired", $realtime);
        $display("quad_float_divide regression: fail");
        $finish;
      end
    end
  end

  localparam logic [63:0] One = 64'h3fff_0000_0000_0000;
  localparam logic [63:0] Inf = 64'h7fff_0000_0000_0000;
  localparam logic [63:0] MaxHi = 64'h7ffe_ffff_ffff_ffff;
  localparam logic [63:0] Z = 64'h0;

  row_t rows[] = '{
    '{One, Z, One, Z, 1, One, Z, 5'h0},
    '{Z, Z, Z, Z, 1, DNAN_HI, '1, FL_NV},
    '{One, Z, 64'h8000_0000_0000_0000, Z, 1, 64'hffff_0000_0000_0000, Z, FL_DZ},
    '{64'h8000_0000_0000_0000, Z, One, Z, 1, 64'h8000_0000_0000_0000, Z, 5'h0},
    '{Inf, Z, 64'hffff_0000_0000_0000, Z, 1, DNAN_HI, '1, FL_NV},
    '{Inf, Z, 64'hbfff_0000_0000_0000, Z, 1, 64'hffff_0000_0000_0000, Z, 5'h0},
    '{One, Z, Inf, Z, 1, Z, Z, 5'h0},
    '{64'h7fff_0000_0000_0001, Z, 64'h7fff_4000_0000_0000, 64'h5, 1,
      64'h7fff_c000_0000_0000, 64'h5, FL_NV},
    '{64'h7fff_0000_0000_0001, Z, 64'hffff_8000_0000_0000, Z, 1,
      64'h7fff_8000_0000_0001, Z, FL_NV},
    '{64'h7fff_8000_0000_0001, Z, 64'h7fff_8000_0000_0002, Z, 1,
      64'h7fff_8000_0000_0002, Z, 5'h0},
    '{'1, '1, One, Z, 1, '1, '1, 5'h0},
    '{One, Z, '1, '1, 1, '1, '1, 5'h0},
    '{MaxHi, '1, MaxHi, '1, 1, One, Z, 5'h0},
    '{MaxHi, '1, Z, 64'h1, 0, Z, Z, 5'h0},
    '{Z, 64'h1, MaxHi, '1, 0, Z, Z, 5'h0},
    '{Z, 64'h1, Z, 64'h3, 0, Z, Z, 5'h0},
    '{64'h0000_ffff_ffff_ffff, '1, 64'h0000_8000_0000_0000, Z, 0, Z, Z, 5'h0},
    '{64'h4000_0000_0000_0000, Z, 64'h4000_8000_0000_0000, Z, 0, Z, Z, 5'h0},
    '{64'hc005_5555_5555_5555, 64'h5555_5555_5555_5555, 64'h3ffd_aaaa_aaaa_aaaa, 64'h1,
      0, Z, Z, 5'h0},
    '{64'h0001_0000_0000_0000, Z, 64'h4000_0000_0000_0000, Z, 0, Z, Z, 5'h0}
  };

  logic [1:0] phase_rm[8] = '{RM_NEAR, RM_ZERO, RM_UP, RM_DOWN,
                              RM_NEAR, RM_UP, RM_DOWN, RM_ZERO};
  logic [4:0] phase_te[8] = '{5'h00, 5'h1f, 5'h04, 5'h01, 5'h04, 5'h00, 5'h1f, 5'h0a};

  initial begin
    logic [127:0] a, b;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed table under reset settings
    foreach (rows[i])
      send_word(rows[i].xh, rows[i].xl, rows[i].yh, rows[i].yl, rows[i].typed,
                rows[i].qh, rows[i].ql, rows[i].fl);

    // random phases across rounding modes and trap masks
    for (int p = 0; p < 8; p++) begin
      set_config(phase_rm[p], phase_te[p]);
      calm = p == 3;
      for (int n = 0; n < 135; n++) begin
        a = rand_operand();
        b = rand_operand();
        send_word(a[127:64], a[63:0], b[127:64], b[63:0], 0, Z, Z, 5'h0);
      end
    end
    calm = 1'b0;
    s_tvalid <= 1'b0;
    @(posedge clk);

    while (quot_queue.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    $display("divided %0d operand pairs over 8 mode/trap settings, %0d results checked",
             words_in, words_out);
    $display("  %0d inexact results, %0d trapped results", inexact_seen, traps_seen);
    if (errors == 0 && quot_queue.size() == 0) begin
      $display("quad_float_divide regression: pass");
    end else begin
      $display("quad_float_divide regression: fail");
    end
    $finish;
  end

endmodule
`default_nettype wire
